### sv/trp_pkg.sv
`default_nettype none

package trp_pkg;

    localparam int GRID_W_DEF   = 30;
    localparam int GRID_H_DEF   = 30;
    localparam int MAX_ROWS_OUT = 30;

    localparam int KIND_W     = 3;
    localparam int AMT_W      = 10;
    localparam int SEL_W      = 2;
    localparam int COORD_W    = 5;
    localparam int ROWBITS_W  = 30;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 48;
    localparam int CFG_ADDR_W = 1;

    localparam logic [COORD_W-1:0] HOME_RST = 5'd15;

    localparam logic [CFG_ADDR_W-1:0] CFG_HOME_X = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_HOME_Y = 1'b1;

    localparam logic [SEL_W-1:0] PEN_SEL_INVALID = 2'd3;

    typedef enum logic [KIND_W-1:0] {
        K_STEP       = 3'd0,
        K_TURN_RIGHT = 3'd1,
        K_TURN_LEFT  = 3'd2,
        K_SET_PEN    = 3'd3,
        K_CLEAR      = 3'd4,
        K_QUERY      = 3'd5,
        K_READ       = 3'd6,
        K_SESSION    = 3'd7
    } kind_t;

    typedef enum logic [1:0] {
        PEN_HOVER = 2'd0,
        PEN_DRAW  = 2'd1,
        PEN_ERASE = 2'd2
    } pen_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_QUERY,
        ST_W_READ,
        ST_W_WRITE,
        ST_R_ISSUE,
        ST_R_DATA
    } fsm_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clear;
    } mem_ctl_t;

    typedef struct packed {
        logic                 is_row;
        logic [COORD_W-1:0]   pos_col;
        logic [COORD_W-1:0]   pos_row;
        logic [COORD_W-1:0]   row_index;
        logic [ROWBITS_W-1:0] row_bits;
        logic                 last;
    } out_item_t;

    typedef struct packed {
        logic up;
        logic down;
        logic left;
        logic right;
    } dir_t;

    // heading 0 is up, then clockwise in 45 degree steps
    function automatic dir_t heading_dir(input logic [2:0] h);
        dir_t d;
        d.up    = (h == 3'd7) || (h == 3'd0) || (h == 3'd1);
        d.right = (h == 3'd1) || (h == 3'd2) || (h == 3'd3);
        d.down  = (h == 3'd3) || (h == 3'd4) || (h == 3'd5);
        d.left  = (h == 3'd5) || (h == 3'd6) || (h == 3'd7);
        return d;
    endfunction

endpackage

`default_nettype wire

### sv/trp_canvas_mem.sv
`default_nettype none

module trp_canvas_mem #(
    parameter int GRID_W = trp_pkg::GRID_W_DEF,
    parameter int GRID_H = trp_pkg::GRID_H_DEF
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  trp_pkg::mem_ctl_t          ctl,
    input  wire [$clog2(GRID_H)-1:0]   addr,
    input  wire [GRID_W-1:0]           wdata,
    output logic [GRID_W-1:0]          rdata
);
    import trp_pkg::*;

    logic [GRID_W-1:0] row_mem [GRID_H];
    logic [GRID_W-1:0] rd_row_reg;
    logic [GRID_H-1:0] valid_reg;
    logic              rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            row_mem[addr] <= wdata;
        end
        if (ctl.rd_en)
        begin
            rd_row_reg <= row_mem[addr];
        end
    end

    // rows never written since the last clear read as blank
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.clear)
            begin
                valid_reg <= '0;
            end
            else if (ctl.wr_en)
            begin
                valid_reg[addr] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                rd_valid_reg <= valid_reg[addr];
            end
        end
    end

    assign rdata = rd_valid_reg ? rd_row_reg : '0;

endmodule

`default_nettype wire

### sv/trp_pen_ctrl.sv
`default_nettype none

module trp_pen_ctrl #(
    parameter int GRID_W = trp_pkg::GRID_W_DEF,
    parameter int GRID_H = trp_pkg::GRID_H_DEF
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             in_valid,
    output logic                            in_ready,
    input  wire [trp_pkg::KIND_W-1:0]       kind,
    input  wire [trp_pkg::AMT_W-1:0]        amount,
    input  wire [trp_pkg::SEL_W-1:0]        pen_select,
    input  wire [$clog2(GRID_W)-1:0]        home_col,
    input  wire [$clog2(GRID_H)-1:0]        home_row,
    output trp_pkg::mem_ctl_t               mem_ctl,
    output logic [$clog2(GRID_H)-1:0]       mem_addr,
    output logic [GRID_W-1:0]               mem_wdata,
    input  wire [GRID_W-1:0]                mem_rdata,
    output logic                            out_valid,
    input  wire                             out_ready,
    output trp_pkg::out_item_t              out_item
);
    import trp_pkg::*;

    localparam int CW   = $clog2(GRID_W);
    localparam int RAW  = $clog2(GRID_H);
    localparam int ROWS = (GRID_H < MAX_ROWS_OUT) ? GRID_H : MAX_ROWS_OUT;
    localparam logic [CW-1:0]  COL_MAX  = CW'(GRID_W - 1);
    localparam logic [RAW-1:0] ROW_MAX  = RAW'(GRID_H - 1);
    localparam logic [RAW-1:0] ROW_LAST = RAW'(ROWS - 1);
    localparam logic [CW-1:0]  COL_RST  =
        CW'((int'(HOME_RST) < GRID_W - 1) ? int'(HOME_RST) : GRID_W - 1);
    localparam logic [RAW-1:0] ROW_RST  =
        RAW'((int'(HOME_RST) < GRID_H - 1) ? int'(HOME_RST) : GRID_H - 1);

    fsm_t           state_reg,   state_next;
    logic [CW-1:0]  pen_col_reg, pen_col_next;
    logic [RAW-1:0] pen_row_reg, pen_row_next;
    logic [2:0]     heading_reg, heading_next;
    pen_t           pen_reg,     pen_next;
    logic [AMT_W-1:0] cnt_reg,   cnt_next;
    logic [RAW-1:0] rrow_reg,    rrow_next;
    logic           out_valid_reg, out_valid_next;
    out_item_t      out_item_reg, out_item_next;

    dir_t        dir;
    logic        blocked;
    logic        out_free;
    logic [2:0]  turn;
    logic        accept;
    kind_t       cmd;

    assign dir      = heading_dir(heading_reg);
    assign blocked  = (dir.left  && (pen_col_reg == '0)) ||
                      (dir.right && (pen_col_reg == COL_MAX)) ||
                      (dir.up    && (pen_row_reg == '0)) ||
                      (dir.down  && (pen_row_reg == ROW_MAX));
    // output slot is empty next cycle
    assign out_free = !out_valid_reg || out_ready;
    assign turn     = (amount == '0) ? 3'd1 : amount[2:0];
    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign cmd      = kind_t'(kind);

    always_comb
    begin
        state_next     = state_reg;
        pen_col_next   = pen_col_reg;
        pen_row_next   = pen_row_reg;
        heading_next   = heading_reg;
        pen_next       = pen_reg;
        cnt_next       = cnt_reg;
        rrow_next      = rrow_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_item_next  = out_item_reg;
        mem_ctl        = '0;
        mem_addr       = pen_row_reg;
        mem_wdata      = mem_rdata;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd)
                        K_STEP:
                        begin
                            if (amount != '0)
                            begin
                                cnt_next   = amount;
                                state_next = ST_W_READ;
                            end
                        end
                        K_TURN_RIGHT: heading_next = heading_reg + turn;
                        K_TURN_LEFT:  heading_next = heading_reg - turn;
                        K_SET_PEN:
                        begin
                            if (pen_select != PEN_SEL_INVALID)
                            begin
                                pen_next = pen_t'(pen_select);
                            end
                        end
                        K_CLEAR:      mem_ctl.clear = 1'b1;
                        K_QUERY:      state_next = ST_QUERY;
                        K_READ:
                        begin
                            rrow_next  = '0;
                            state_next = ST_R_ISSUE;
                        end
                        K_SESSION:
                        begin
                            mem_ctl.clear = 1'b1;
                            pen_col_next  = home_col;
                            pen_row_next  = home_row;
                            heading_next  = 3'd0;
                            pen_next      = PEN_DRAW;
                        end
                        default: ;
                    endcase
                end
            end
            ST_QUERY:
            begin
                if (out_free)
                begin
                    out_item_next.is_row    = 1'b0;
                    out_item_next.pos_col   = COORD_W'(pen_col_reg);
                    out_item_next.pos_row   = COORD_W'(pen_row_reg);
                    out_item_next.row_index = '0;
                    out_item_next.row_bits  = '0;
                    out_item_next.last      = 1'b1;
                    out_valid_next          = 1'b1;
                    state_next              = ST_IDLE;
                end
            end
            ST_W_READ:
            begin
                // the rest of the command is dropped at the canvas edge
                if (blocked)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    mem_ctl.rd_en = 1'b1;
                    state_next    = ST_W_WRITE;
                end
            end
            ST_W_WRITE:
            begin
                mem_ctl.wr_en = 1'b1;
                if (pen_reg == PEN_DRAW)
                begin
                    mem_wdata[pen_col_reg] = 1'b1;
                end
                else if (pen_reg == PEN_ERASE)
                begin
                    mem_wdata[pen_col_reg] = 1'b0;
                end
                if (dir.right)
                begin
                    pen_col_next = pen_col_reg + CW'(1);
                end
                else if (dir.left)
                begin
                    pen_col_next = pen_col_reg - CW'(1);
                end
                if (dir.down)
                begin
                    pen_row_next = pen_row_reg + RAW'(1);
                end
                else if (dir.up)
                begin
                    pen_row_next = pen_row_reg - RAW'(1);
                end
                cnt_next   = cnt_reg - AMT_W'(1);
                state_next = (cnt_reg == AMT_W'(1)) ? ST_IDLE : ST_W_READ;
            end
            ST_R_ISSUE:
            begin
                mem_addr = rrow_reg;
                if (out_free)
                begin
                    mem_ctl.rd_en = 1'b1;
                    state_next    = ST_R_DATA;
                end
            end
            ST_R_DATA:
            begin
                mem_addr                = rrow_reg;
                out_item_next.is_row    = 1'b1;
                out_item_next.pos_col   = '0;
                out_item_next.pos_row   = '0;
                out_item_next.row_index = COORD_W'(rrow_reg);
                out_item_next.row_bits  = ROWBITS_W'(mem_rdata);
                out_item_next.last      = (rrow_reg == ROW_LAST);
                out_valid_next          = 1'b1;
                if (rrow_reg == ROW_LAST)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    rrow_next  = rrow_reg + RAW'(1);
                    state_next = ST_R_ISSUE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pen_col_reg   <= COL_RST;
            pen_row_reg   <= ROW_RST;
            heading_reg   <= 3'd0;
            pen_reg       <= PEN_DRAW;
            cnt_reg       <= '0;
            rrow_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pen_col_reg   <= pen_col_next;
            pen_row_reg   <= pen_row_next;
            heading_reg   <= heading_next;
            pen_reg       <= pen_next;
            cnt_reg       <= cnt_next;
            rrow_reg      <= rrow_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

`default_nettype wire

### sv/turtle_raster_plotter_unit.sv
// Turtle pen plotter on a one-bit-per-cell canvas of GRID_W x GRID_H cells.
// Command requests come in on s_*: s_tuser is the command kind, s_tdata the
// step/turn amount and pen selection. Replies leave on m_*: a position reply
// (m_tuser = 0) or one reply per canvas row (m_tuser = 1); m_tlast marks
// the final reply of a command. cfg_we/cfg_addr/cfg_wdata set the home
// column and row, applied (saturated to the canvas) on session reset.
// Turn, pen, clear and session reset complete in the idle state. A step
// command reads then writes back the canvas row for each cell moved,
// through the single-port row memory, and stops at the canvas edge.
// A position reply goes through the query state to the output register.
// A canvas readout issues one memory read per row and sends that row
// before the next read; it gives the first 30 rows at most.
// A new request is taken whenever the command sequencer is idle, even while
// a reply still waits in the output register. When the receiver stalls,
// the reply holds in that register and a readout pauses before its next
// memory read. Reset blanks the canvas at once through per-row valid bits,
// homes the pen at (15,15) heading up in draw mode; no clearing pass.
`default_nettype none

module turtle_raster_plotter_unit #(
    parameter int GRID_W = trp_pkg::GRID_W_DEF,
    parameter int GRID_H = trp_pkg::GRID_H_DEF
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire [trp_pkg::S_TDATA_W-1:0]       s_tdata,   // amount[9:0], pen_select[11:10]
    input  wire [trp_pkg::KIND_W-1:0]          s_tuser,   // kind[2:0]
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [trp_pkg::M_TDATA_W-1:0]      m_tdata,   // pos_col[4:0], pos_row[9:5],
                                                          // row_index[14:10], row_bits[44:15]
    output logic [0:0]                         m_tuser,   // is_row[0]
    output logic                               m_tlast,
    input  wire                                cfg_we,
    input  wire [trp_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  wire [trp_pkg::COORD_W-1:0]         cfg_wdata
);
    import trp_pkg::*;

    localparam int CW  = $clog2(GRID_W);
    localparam int RAW = $clog2(GRID_H);

    logic [COORD_W-1:0] home_x_reg;
    logic [COORD_W-1:0] home_y_reg;
    logic [CW-1:0]      home_col;
    logic [RAW-1:0]     home_row;
    mem_ctl_t           mem_ctl;
    logic [RAW-1:0]     mem_addr;
    logic [GRID_W-1:0]  mem_wdata;
    logic [GRID_W-1:0]  mem_rdata;
    out_item_t          out_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            home_x_reg <= HOME_RST;
            home_y_reg <= HOME_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == CFG_HOME_X)
            begin
                home_x_reg <= cfg_wdata;
            end
            if (cfg_addr == CFG_HOME_Y)
            begin
                home_y_reg <= cfg_wdata;
            end
        end
    end

    // home is clamped onto the canvas
    assign home_col = (int'(home_x_reg) < GRID_W - 1) ? CW'(home_x_reg)  : CW'(GRID_W - 1);
    assign home_row = (int'(home_y_reg) < GRID_H - 1) ? RAW'(home_y_reg) : RAW'(GRID_H - 1);

    trp_pen_ctrl #(
        .GRID_W (GRID_W),
        .GRID_H (GRID_H)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .kind       (s_tuser),
        .amount     (s_tdata[AMT_W-1:0]),
        .pen_select (s_tdata[AMT_W+SEL_W-1:AMT_W]),
        .home_col   (home_col),
        .home_row   (home_row),
        .mem_ctl    (mem_ctl),
        .mem_addr   (mem_addr),
        .mem_wdata  (mem_wdata),
        .mem_rdata  (mem_rdata),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_item   (out_item)
    );

    trp_canvas_mem #(
        .GRID_W (GRID_W),
        .GRID_H (GRID_H)
    ) u_canvas (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mem_ctl),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign m_tdata = {3'b000, out_item.row_bits, out_item.row_index,
                      out_item.pos_row, out_item.pos_col};
    assign m_tuser = out_item.is_row;
    assign m_tlast = out_item.last;

`ifndef SYNTHESIS
    a_no_rd_wr_same_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_ctl.rd_en && mem_ctl.wr_en))
        else $error("canvas read and write issued together");

    a_wr_follows_rd: assert property (@(posedge clk) disable iff (!rst_n)
        mem_ctl.wr_en |-> $past(mem_ctl.rd_en))
        else $error("canvas write without preceding row read");

    a_wr_same_row: assert property (@(posedge clk) disable iff (!rst_n)
        mem_ctl.wr_en |-> (mem_addr == $past(mem_addr)))
        else $error("canvas write back to a different row than read");

    a_clear_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mem_ctl.clear |-> (s_tready && !mem_ctl.rd_en && !mem_ctl.wr_en))
        else $error("canvas clear during an access");
`endif

endmodule

`default_nettype wire
